>>> sv/sparse_zero_elided_block_store_unit_assert.svh
// Assertion macros used by the checker file of the sparse block store.
`ifndef SPARSE_ZERO_ELIDED_BLOCK_STORE_UNIT_ASSERT_SVH
`define SPARSE_ZERO_ELIDED_BLOCK_STORE_UNIT_ASSERT_SVH

// Condition in one cycle implies a consequence in the same cycle.
`define SZEB_ASSERT_NOW(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("sparse store: same-cycle check failed");

// Condition in one cycle implies a consequence in the next cycle.
`define SZEB_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("sparse store: next-cycle check failed");

`endif

>>> sv/szeb_pkg.sv
// Types and codes shared by the modules of the sparse block store.
package szeb_pkg;

   // Opcodes of an input word.
   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_TRIM  = 2'd2;

   // Widest block and word indexes that the parameters allow.
   localparam int BLK_MAX_W  = 16;
   localparam int WORD_MAX_W = 16;

   typedef enum logic [1:0] {
      KIND_NOP,
      KIND_READ,
      KIND_STORE
   } kind_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FETCH,
      ST_EXEC
   } state_type;

   // A classified command as the front hands it to the back.
   typedef struct packed {
      kind_type              kind;
      logic [BLK_MAX_W-1:0]  block;
      logic [WORD_MAX_W-1:0] word;
      logic [63:0]           data;
      logic                  last;
   } cmd_type;

   // One result word.
   typedef struct packed {
      logic [63:0] read_data;
      logic        status;
      logic [8:0]  allocated_blocks;
      logic        request_done;
   } rsp_type;

endpackage

>>> sv/szeb_front.sv
// Front end: accepts input words, splits the address and queues classified commands.
module szeb_front #(
   parameter int NUM_BLOCKS      = 1024,
   parameter int WORDS_PER_BLOCK = 512
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic [1:0]        req_op,
   input  logic [18:0]       req_word_addr,
   input  logic [63:0]       req_write_data,
   input  logic              req_last_word,
   input  logic              hold,
   output logic              req_full,
   output logic              cmd_vld,
   output szeb_pkg::cmd_type cmd,
   input  logic              cmd_pop
);
   import szeb_pkg::*;

   localparam logic [31:0] RECIP = 32'((64'd1 << 32) / WORDS_PER_BLOCK);
   localparam logic [35:0] WPB36 = 36'(WORDS_PER_BLOCK);
   localparam logic [35:0] NB36  = 36'(NUM_BLOCKS);

   logic        a_vld_ff, a_vld_in;
   logic [18:0] a_addr_ff;
   logic [50:0] a_prod_ff;
   logic [1:0]  a_op_ff;
   logic [63:0] a_data_ff;
   logic        a_last_ff;

   cmd_type     q_mem_ff [2];
   logic        q_wp_ff, q_rp_ff;
   logic [1:0]  q_cnt_ff, q_cnt_in;
   logic        q_full, q_push, accept;

   logic [18:0] quot0, quot;
   logic [35:0] rem0, rem;
   cmd_type     cls;

   assign q_full   = (q_cnt_ff == 2'd2);
   assign q_push   = a_vld_ff && !q_full;
   assign req_full = hold || (a_vld_ff && q_full);
   assign accept   = req_push && !req_full;
   assign a_vld_in = accept ? 1'b1 : (q_push ? 1'b0 : a_vld_ff);

   // Stage A registers the word and the reciprocal product of its address.
   always_ff @(posedge clock) begin
      if (reset) begin
         a_vld_ff <= 1'b0;
      end else begin
         a_vld_ff <= a_vld_in;
      end
      if (accept) begin
         a_addr_ff <= req_word_addr;
         a_prod_ff <= 51'(req_word_addr) * 51'(RECIP);
         a_op_ff   <= req_op;
         a_data_ff <= req_write_data;
         a_last_ff <= req_last_word;
      end
   end

   // Stage B corrects the quotient estimate and classifies the word.
   always_comb begin
      quot0 = a_prod_ff[50:32];
      rem0  = 36'(a_addr_ff) - 36'(quot0) * WPB36;
      if (rem0 >= WPB36) begin
         quot = quot0 + 19'd1;
         rem  = rem0 - WPB36;
      end else begin
         quot = quot0;
         rem  = rem0;
      end
      cls.block = BLK_MAX_W'(quot);
      cls.word  = WORD_MAX_W'(rem);
      cls.last  = a_last_ff;
      cls.data  = a_data_ff;
      case (a_op_ff)
         OP_READ:  cls.kind = KIND_READ;
         OP_WRITE: cls.kind = KIND_STORE;
         OP_TRIM: begin
            cls.kind = KIND_STORE;
            cls.data = 64'd0;
         end
         default:  cls.kind = KIND_NOP;
      endcase
      if (36'(quot) >= NB36) begin
         cls.kind = KIND_NOP;
      end
   end

   // Two-entry command queue toward the back end.
   always_comb begin
      q_cnt_in = q_cnt_ff;
      if (q_push && !cmd_pop) begin
         q_cnt_in = q_cnt_ff + 2'd1;
      end else if (!q_push && cmd_pop) begin
         q_cnt_in = q_cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         q_wp_ff  <= 1'b0;
         q_rp_ff  <= 1'b0;
         q_cnt_ff <= 2'd0;
      end else begin
         q_cnt_ff <= q_cnt_in;
         if (q_push) begin
            q_wp_ff <= !q_wp_ff;
         end
         if (cmd_pop) begin
            q_rp_ff <= !q_rp_ff;
         end
      end
      if (q_push) begin
         q_mem_ff[q_wp_ff] <= cls;
      end
   end

   assign cmd_vld = (q_cnt_ff != 2'd0);
   assign cmd     = q_mem_ff[q_rp_ff];

endmodule

>>> sv/szeb_back.sv
// Back end: block map, frame memory, nonzero counts and free stack.
module szeb_back #(
   parameter int NUM_BLOCKS      = 1024,
   parameter int WORDS_PER_BLOCK = 512,
   parameter int POOL_FRAMES     = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [8:0]        csr_wr_data,
   input  logic              cmd_vld,
   input  szeb_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              hold,
   input  logic              rsp_full,
   output logic              rsp_push,
   output szeb_pkg::rsp_type rsp
);
   import szeb_pkg::*;

   localparam int BLK_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int WORD_W  = $clog2(WORDS_PER_BLOCK);
   localparam int FRAME_W = (POOL_FRAMES > 1) ? $clog2(POOL_FRAMES) : 1;
   localparam int TOP_W   = $clog2(POOL_FRAMES + 1);
   localparam int CNT_W   = $clog2(WORDS_PER_BLOCK + 1);
   localparam int FA_W    = FRAME_W + WORD_W;
   localparam int CLR_W   = (FA_W > BLK_W) ? FA_W : BLK_W;
   localparam logic [TOP_W-1:0] POOL_TOP = TOP_W'(POOL_FRAMES);

   // Memories.
   logic [FRAME_W:0]     map_mem   [2**BLK_W];
   logic [63:0]          frame_mem [2**FA_W];
   logic [CNT_W-1:0]     cnt_mem   [POOL_FRAMES];
   logic [FRAME_W-1:0]   stk_mem   [POOL_FRAMES];

   state_type            state_ff, state_in;
   cmd_type              cmd_ff;
   logic [CLR_W-1:0]     clr_ff;
   logic [FRAME_W:0]     map_rd_ff;
   logic [63:0]          word_rd_ff;
   logic [CNT_W-1:0]     cnt_rd_ff;
   logic [FRAME_W-1:0]   stk_rd_ff, stk_idx_ff;
   logic                 stk_sel_ff;
   logic [POOL_FRAMES-1:0] stk_vld_ff;
   logic [TOP_W-1:0]     free_top_ff, free_top_in;
   logic [TOP_W-1:0]     mapped_ff, mapped_in;
   logic [8:0]           reserve_ff;

   // Write ports decided combinationally.
   logic                 map_we, fw_we, cnt_we, stk_we;
   logic [BLK_W-1:0]     map_wa;
   logic [FRAME_W:0]     map_wd;
   logic [FA_W-1:0]      fw_wa;
   logic [63:0]          fw_wd;
   logic [FRAME_W-1:0]   cnt_wa, stk_wa, stk_wd;
   logic [CNT_W-1:0]     cnt_wd;

   logic                 m_vld;
   logic [FRAME_W-1:0]   m_frame, new_frame, top_idx;
   logic [BLK_W-1:0]     blk;
   logic [WORD_W-1:0]    wd;
   logic [CNT_W-1:0]     dec_cnt;
   logic                 drop;

   assign m_vld     = map_rd_ff[FRAME_W];
   assign m_frame   = map_rd_ff[FRAME_W-1:0];
   assign blk       = cmd_ff.block[BLK_W-1:0];
   assign wd        = cmd_ff.word[WORD_W-1:0];
   assign new_frame = stk_sel_ff ? stk_rd_ff : stk_idx_ff;
   assign top_idx   = FRAME_W'(free_top_ff - TOP_W'(1));
   assign hold      = (state_ff == ST_CLEAR);
   assign drop      = (free_top_ff == '0) || (17'(free_top_ff) <= 17'(reserve_ff));
   assign dec_cnt   = ((word_rd_ff != 64'd0) && (cnt_rd_ff != '0)) ?
                      cnt_rd_ff - CNT_W'(1) : cnt_rd_ff;

   // Sequencer: next state, memory writes and the result word.
   always_comb begin
      state_in    = state_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      map_we      = 1'b0;
      fw_we       = 1'b0;
      cnt_we      = 1'b0;
      stk_we      = 1'b0;
      map_wa      = blk;
      map_wd      = '0;
      fw_wa       = {m_frame, wd};
      fw_wd       = cmd_ff.data;
      cnt_wa      = m_frame;
      cnt_wd      = '0;
      stk_wa      = FRAME_W'(free_top_ff);
      stk_wd      = m_frame;
      free_top_in = free_top_ff;
      mapped_in   = mapped_ff;
      rsp.read_data    = 64'd0;
      rsp.status       = 1'b0;
      rsp.request_done = cmd_ff.last;
      case (state_ff)
         ST_CLEAR: begin
            map_we = 1'b1;
            map_wa = clr_ff[BLK_W-1:0];
            fw_we  = 1'b1;
            fw_wa  = clr_ff[FA_W-1:0];
            fw_wd  = 64'd0;
            if (clr_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (cmd_vld) begin
               cmd_pop  = 1'b1;
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (!rsp_full) begin
               rsp_push = 1'b1;
               state_in = ST_IDLE;
               if (cmd_ff.kind == KIND_READ) begin
                  rsp.read_data = m_vld ? word_rd_ff : 64'd0;
               end else if (cmd_ff.kind == KIND_STORE) begin
                  if (m_vld) begin
                     fw_we = 1'b1;
                     if (cmd_ff.data != 64'd0) begin
                        if (word_rd_ff == 64'd0) begin
                           cnt_we = 1'b1;
                           cnt_wd = cnt_rd_ff + CNT_W'(1);
                        end
                     end else begin
                        cnt_we = 1'b1;
                        cnt_wd = dec_cnt;
                        if (dec_cnt == '0) begin
                           map_we = 1'b1;
                           if (free_top_ff < POOL_TOP) begin
                              stk_we      = 1'b1;
                              free_top_in = free_top_ff + TOP_W'(1);
                           end
                           if (mapped_ff != '0) begin
                              mapped_in = mapped_ff - TOP_W'(1);
                           end
                        end
                     end
                  end else if (cmd_ff.data != 64'd0) begin
                     if (drop) begin
                        rsp.status = 1'b1;
                     end else begin
                        free_top_in = free_top_ff - TOP_W'(1);
                        map_we      = 1'b1;
                        map_wd      = {1'b1, new_frame};
                        fw_we       = 1'b1;
                        fw_wa       = {new_frame, wd};
                        cnt_we      = 1'b1;
                        cnt_wa      = new_frame;
                        cnt_wd      = CNT_W'(1);
                        mapped_in   = mapped_ff + TOP_W'(1);
                     end
                  end
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp.allocated_blocks = 9'(mapped_in);
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_ff      <= '0;
         free_top_ff <= POOL_TOP;
         mapped_ff   <= '0;
         reserve_ff  <= 9'd0;
         stk_vld_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         free_top_ff <= free_top_in;
         mapped_ff   <= mapped_in;
         if (state_ff == ST_CLEAR) begin
            clr_ff <= clr_ff + CLR_W'(1);
         end
         if (csr_wr_en) begin
            reserve_ff <= csr_wr_data;
         end
         if (stk_we) begin
            stk_vld_ff[stk_wa] <= 1'b1;
         end
      end
   end

   // Command capture and memory read ports, all registered.
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && cmd_vld) begin
         cmd_ff    <= cmd;
         map_rd_ff <= map_mem[cmd.block[BLK_W-1:0]];
      end
      if (state_ff == ST_FETCH) begin
         word_rd_ff <= frame_mem[{m_frame, wd}];
         cnt_rd_ff  <= cnt_mem[m_frame];
         stk_rd_ff  <= stk_mem[top_idx];
         stk_sel_ff <= stk_vld_ff[top_idx];
         stk_idx_ff <= top_idx;
      end
   end

   // Memory write ports.
   always_ff @(posedge clock) begin
      if (map_we) begin
         map_mem[map_wa] <= map_wd;
      end
      if (fw_we) begin
         frame_mem[fw_wa] <= fw_wd;
      end
      if (cnt_we) begin
         cnt_mem[cnt_wa] <= cnt_wd;
      end
      if (stk_we) begin
         stk_mem[stk_wa] <= stk_wd;
      end
   end

endmodule

>>> sv/szeb_rsp_q.sv
// Two-entry result queue that holds words until the receiver pops them.
module szeb_rsp_q (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  szeb_pkg::rsp_type push_word,
   output logic              full,
   input  logic              pop,
   output logic              empty,
   output szeb_pkg::rsp_type head
);
   import szeb_pkg::*;

   rsp_type    mem_ff [2];
   logic       wp_ff, rp_ff, do_pop;
   logic [1:0] cnt_ff, cnt_in;

   assign full   = (cnt_ff == 2'd2);
   assign empty  = (cnt_ff == 2'd0);
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rp_ff];

   // Occupancy update.
   always_comb begin
      cnt_in = cnt_ff;
      if (push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (!push && do_pop) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
         if (push) begin
            wp_ff <= !wp_ff;
         end
         if (do_pop) begin
            rp_ff <= !rp_ff;
         end
      end
      if (push) begin
         mem_ff[wp_ff] <= push_word;
      end
   end

endmodule

>>> sv/sparse_zero_elided_block_store_unit.sv
// Top level of the sparse zero-elided word store.
// Input words arrive on a queue-style port: a word is taken when req_push is
// high and req_full is low. Each word carries an opcode (read, write, trim),
// a logical word address, write data and an end-of-request flag.
// Every input word yields exactly one result word on the rsp_ side, shown
// while rsp_empty is low and taken when rsp_pop is high.
// From acceptance to the result on the ports: the front stage splits the address
// and queues the command, then the back sequencer takes each word through map
// read, frame word / count / free stack read, and update and result push, the
// last held while the result queue is full. The sequencer takes a new word only
// after the result of the last one has been pushed.
// The reserve register is written through csr_wr_en and csr_wr_data.
// After reset a clearing pass zeroes the block map and the frame memory, one
// entry a cycle, until every entry of both is zero; req_full stays high for
// that time.
// When the receiver stalls, two results wait in the result queue, one word in
// the sequencer, two commands in the front queue and one in the front stage,
// and then req_full rises.
module sparse_zero_elided_block_store_unit #(
   parameter int NUM_BLOCKS      = 1024,
   parameter int WORDS_PER_BLOCK = 512,
   parameter int POOL_FRAMES     = 256
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_op,
   input  logic [18:0] req_word_addr,
   input  logic [63:0] req_write_data,
   input  logic        req_last_word,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [63:0] rsp_read_data,
   output logic        rsp_status,
   output logic [8:0]  rsp_allocated_blocks,
   output logic        rsp_request_done,
   input  logic        csr_wr_en,
   input  logic [8:0]  csr_wr_data
);
   import szeb_pkg::*;

   logic    hold, cmd_vld, cmd_pop, rsp_full, rsp_push;
   cmd_type cmd;
   rsp_type rsp_word, rsp_head;

   // Front end: acceptance and classification.
   szeb_front #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .WORDS_PER_BLOCK (WORDS_PER_BLOCK)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_op         (req_op),
      .req_word_addr  (req_word_addr),
      .req_write_data (req_write_data),
      .req_last_word  (req_last_word),
      .hold           (hold),
      .req_full       (req_full),
      .cmd_vld        (cmd_vld),
      .cmd            (cmd),
      .cmd_pop        (cmd_pop)
   );

   // Back end: storage and frame management.
   szeb_back #(
      .NUM_BLOCKS      (NUM_BLOCKS),
      .WORDS_PER_BLOCK (WORDS_PER_BLOCK),
      .POOL_FRAMES     (POOL_FRAMES)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd_vld     (cmd_vld),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .hold        (hold),
      .rsp_full    (rsp_full),
      .rsp_push    (rsp_push),
      .rsp         (rsp_word)
   );

   // Result queue toward the receiver.
   szeb_rsp_q u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (rsp_push),
      .push_word (rsp_word),
      .full      (rsp_full),
      .pop       (rsp_pop),
      .empty     (rsp_empty),
      .head      (rsp_head)
   );

   assign rsp_read_data        = rsp_head.read_data;
   assign rsp_status           = rsp_head.status;
   assign rsp_allocated_blocks = rsp_head.allocated_blocks;
   assign rsp_request_done     = rsp_head.request_done;

endmodule

>>> sv/szeb_checker.sv
// Port-level checks of the sparse block store and their binding to the top level.
`include "sparse_zero_elided_block_store_unit_assert.svh"

module szeb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_push,
   input logic        req_full,
   input logic [1:0]  req_op,
   input logic [18:0] req_word_addr,
   input logic [63:0] req_write_data,
   input logic        req_last_word,
   input logic        rsp_empty,
   input logic        rsp_pop,
   input logic [63:0] rsp_read_data,
   input logic        rsp_status,
   input logic [8:0]  rsp_allocated_blocks,
   input logic        rsp_request_done,
   input logic        csr_wr_en,
   input logic [8:0]  csr_wr_data
);

   // A dropped write never carries read data.
   `SZEB_ASSERT_NOW(a_drop_no_data, clock, reset, !rsp_empty && rsp_status, rsp_read_data == 64'd0)

   // The clearing pass blocks input right after reset.
   `SZEB_ASSERT_NOW(a_clear_blocks, clock, reset, $past(reset), req_full)

   // No result exists right after reset.
   `SZEB_ASSERT_NOW(a_reset_empty, clock, reset, $past(reset), rsp_empty)

   // A waiting result holds while the receiver stalls.
   `SZEB_ASSERT_NEXT(a_rsp_hold, clock, reset, !rsp_empty && !rsp_pop, !rsp_empty && $stable(rsp_read_data))

endmodule

bind sparse_zero_elided_block_store_unit szeb_checker u_szeb_checker (.*);
